// ===== rtl/stes_pkg.sv =====
// Package for the sorted table with smallest-size eviction.
// Field widths, register map, command codes and the stored entry type.
// No dependencies.
`timescale 1ns / 1ps

package stes_pkg;

   localparam int TIME_W      = 32;
   localparam int SIZE_W      = 16;
   localparam int TOTAL_W     = 21;
   localparam int COUNT_OUT_W = 6;

   localparam int DEFAULT_DEPTH = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [TOTAL_W-1:0] CAP_RESET = TOTAL_W'(32768);

   // Command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_EVICT  = 1'b1;

   // Register map: byte address, word index in bit 2 and up
   localparam int         CSR_ADDR_W   = 3;
   localparam logic [0:0] CSR_CAPACITY = 1'b0;

   // One table entry as stored in the RAM
   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [SIZE_W-1:0] size;
   } entry_type;

endpackage

// ===== rtl/sorted_table_evict_smallest.sv =====
// Top level of the sorted table with smallest-size eviction.
// Depends on stes_pkg and on stes_ram for the entry table.
`timescale 1ns / 1ps

// Usage:
//  - Command channel: a transaction is taken at a clock edge with start high
//    and busy low. req_cmd selects insert or evict; req_time_stamp and
//    req_entry_size carry the entry for an insert.
//  - Result channel: each result is shown for one cycle with rsp_valid high.
//    Insert gives one result. Evict gives one result per removed entry, or
//    one empty result when the total already fits; rsp_last marks the final.
//  - The receiver cannot stall: every result must be taken the cycle shown.
//  - Insert into a non-empty table reads down from the top entry, moving
//    each entry with a later timestamp up one slot, then writes the new
//    entry; a refused insert leaves the table as is. Evict gives an empty
//    result when nothing has to go. Else, for each removal, one table walk
//    finds the smallest size and a second closes the gap. The single RAM
//    port pair, one entry per cycle, sets the pace of these walks. busy is
//    high while a command is worked on; a refused insert never raises it.
//  - Configuration (capacity) goes through the APB port; the user must keep
//    to writing it while busy is low, the block itself does not enforce it.
//  - Reset empties the table (count and total zero) and loads capacity 32768;
//    the RAM needs no clearing pass since only held slots are read.
module sorted_table_evict_smallest
   import stes_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // command channel
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_cmd,
   input  logic [TIME_W-1:0]      req_time_stamp,
   input  logic [SIZE_W-1:0]      req_entry_size,
   // result channel
   output logic                   rsp_valid,
   output logic                   rsp_removed_valid,
   output logic [TIME_W-1:0]      rsp_removed_time,
   output logic [SIZE_W-1:0]      rsp_removed_size,
   output logic [TOTAL_W-1:0]     rsp_total_size,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                   rsp_rejected,
   output logic                   rsp_last,
   // configuration port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_INS_WALK  = 3'd1;
   localparam logic [2:0] S_INS_PLACE = 3'd2;
   localparam logic [2:0] S_EV_CHECK  = 3'd3;
   localparam logic [2:0] S_EV_SCAN   = 3'd4;
   localparam logic [2:0] S_EV_SHIFT  = 3'd5;
   localparam logic [2:0] S_EV_REMOVE = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] cap_ff, cap_in;
   logic [TIME_W-1:0]  t_ff, t_in;
   logic [SIZE_W-1:0]  s_ff, s_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   entry_type          min_ff, min_in;
   logic [IDX_W-1:0]   min_idx_ff, min_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_rvalid_ff, rsp_rvalid_in;
   logic [TIME_W-1:0]      rsp_time_ff, rsp_time_in;
   logic [SIZE_W-1:0]      rsp_size_ff, rsp_size_in;
   logic [TOTAL_W-1:0]     rsp_total_ff, rsp_total_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_rej_ff, rsp_rej_in;
   logic                   rsp_last_ff, rsp_last_in;

   // RAM port signals
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   // Derived control values
   logic               csr_wr;
   logic               tbl_full;
   logic               tbl_over;
   logic [IDX_W-1:0]   last_idx;
   logic               scan_take;
   entry_type          scan_min;
   logic [IDX_W-1:0]   scan_idx;
   logic               scan_end;
   logic [CNT_W-1:0]   rem_cnt;
   logic [TOTAL_W-1:0] rem_total;
   logic               rem_last;
   entry_type          new_entry;

   // Entry table
   stes_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Configuration register
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[CSR_ADDR_W-1:2] == CSR_CAPACITY);
   assign cap_in = csr_wr ? pwdata[TOTAL_W-1:0] : cap_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == CSR_CAPACITY) ? 32'(cap_ff) : 32'd0;

   // Insert admission checks
   assign tbl_full = (cnt_ff == CNT_W'(DEPTH));
   assign tbl_over = ({1'b0, total_ff} + (TOTAL_W + 1)'(req_entry_size))
                     > {1'b0, TOTAL_MAX};
   assign last_idx = IDX_W'(cnt_ff - 1'b1);
   assign new_entry = '{stamp: t_ff, size: s_ff};

   // Running minimum: strictly smaller wins, so the first one stays on ties
   assign scan_take = (ptr_ff == '0) || (rd_data.size < min_ff.size);
   assign scan_min  = scan_take ? rd_data : min_ff;
   assign scan_idx  = scan_take ? ptr_ff : min_idx_ff;
   assign scan_end  = (ptr_ff == last_idx);

   // State after the pending removal
   assign rem_cnt   = cnt_ff - 1'b1;
   assign rem_total = total_ff - TOTAL_W'(min_ff.size);
   assign rem_last  = !((rem_total > cap_ff) && (rem_cnt != '0));

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      total_in   = total_ff;
      t_in       = t_ff;
      s_in       = s_ff;
      ptr_in     = ptr_ff;
      min_in     = min_ff;
      min_idx_in = min_idx_ff;

      rsp_valid_in  = 1'b0;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_last_in   = rsp_last_ff;

      rd_addr = ptr_ff;
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               t_in = req_time_stamp;
               s_in = req_entry_size;
               if (req_cmd == CMD_INSERT) begin
                  if (tbl_full || tbl_over) begin
                     // refused: table left as is
                     rsp_valid_in  = 1'b1;
                     rsp_rvalid_in = 1'b0;
                     rsp_time_in   = '0;
                     rsp_size_in   = '0;
                     rsp_total_in  = total_ff;
                     rsp_count_in  = COUNT_OUT_W'(cnt_ff);
                     rsp_rej_in    = 1'b1;
                     rsp_last_in   = 1'b1;
                  end else if (cnt_ff == '0) begin
                     ptr_in   = '0;
                     state_in = S_INS_PLACE;
                  end else begin
                     rd_addr  = last_idx;
                     ptr_in   = last_idx;
                     state_in = S_INS_WALK;
                  end
               end else begin
                  state_in = S_EV_CHECK;
               end
            end
         end

         // Walk down from the top, moving later timestamps up one slot
         S_INS_WALK: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(ptr_ff + 1'b1);
            if (rd_data.stamp > t_ff) begin
               wr_data = rd_data;
               if (ptr_ff == '0) begin
                  state_in = S_INS_PLACE;
               end else begin
                  rd_addr = IDX_W'(ptr_ff - 1'b1);
                  ptr_in  = IDX_W'(ptr_ff - 1'b1);
               end
            end else begin
               wr_data       = new_entry;
               cnt_in        = cnt_ff + 1'b1;
               total_in      = total_ff + TOTAL_W'(s_ff);
               rsp_valid_in  = 1'b1;
               rsp_rvalid_in = 1'b0;
               rsp_time_in   = '0;
               rsp_size_in   = '0;
               rsp_total_in  = total_in;
               rsp_count_in  = COUNT_OUT_W'(cnt_in);
               rsp_rej_in    = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // New entry goes into the slot at the pointer
         S_INS_PLACE: begin
            wr_en         = 1'b1;
            wr_addr       = ptr_ff;
            wr_data       = new_entry;
            cnt_in        = cnt_ff + 1'b1;
            total_in      = total_ff + TOTAL_W'(s_ff);
            rsp_valid_in  = 1'b1;
            rsp_rvalid_in = 1'b0;
            rsp_time_in   = '0;
            rsp_size_in   = '0;
            rsp_total_in  = total_in;
            rsp_count_in  = COUNT_OUT_W'(cnt_in);
            rsp_rej_in    = 1'b0;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         // Start a removal, or report that nothing has to go
         S_EV_CHECK: begin
            if ((total_ff > cap_ff) && (cnt_ff != '0)) begin
               rd_addr  = '0;
               ptr_in   = '0;
               state_in = S_EV_SCAN;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_rvalid_in = 1'b0;
               rsp_time_in   = '0;
               rsp_size_in   = '0;
               rsp_total_in  = total_ff;
               rsp_count_in  = COUNT_OUT_W'(cnt_ff);
               rsp_rej_in    = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // One entry per cycle through the compare unit
         S_EV_SCAN: begin
            min_in     = scan_min;
            min_idx_in = scan_idx;
            if (scan_end) begin
               if (scan_idx == last_idx) begin
                  state_in = S_EV_REMOVE;
               end else begin
                  rd_addr  = IDX_W'(scan_idx + 1'b1);
                  ptr_in   = IDX_W'(scan_idx + 1'b1);
                  state_in = S_EV_SHIFT;
               end
            end else begin
               rd_addr = IDX_W'(ptr_ff + 1'b1);
               ptr_in  = IDX_W'(ptr_ff + 1'b1);
            end
         end

         // Close the gap: move each later entry down one slot
         S_EV_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(ptr_ff - 1'b1);
            wr_data = rd_data;
            if (scan_end) begin
               state_in = S_EV_REMOVE;
            end else begin
               rd_addr = IDX_W'(ptr_ff + 1'b1);
               ptr_in  = IDX_W'(ptr_ff + 1'b1);
            end
         end

         // Report the removed entry and decide whether to go on
         S_EV_REMOVE: begin
            cnt_in        = rem_cnt;
            total_in      = rem_total;
            rsp_valid_in  = 1'b1;
            rsp_rvalid_in = 1'b1;
            rsp_time_in   = min_ff.stamp;
            rsp_size_in   = min_ff.size;
            rsp_total_in  = rem_total;
            rsp_count_in  = COUNT_OUT_W'(rem_cnt);
            rsp_rej_in    = 1'b0;
            rsp_last_in   = rem_last;
            state_in      = rem_last ? S_IDLE : S_EV_CHECK;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         total_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      t_ff          <= t_in;
      s_ff          <= s_in;
      ptr_ff        <= ptr_in;
      min_ff        <= min_in;
      min_idx_ff    <= min_idx_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rej_ff    <= rsp_rej_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_valid = rsp_rvalid_ff;
   assign rsp_removed_time  = rsp_time_ff;
   assign rsp_removed_size  = rsp_size_ff;
   assign rsp_total_size    = rsp_total_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_rejected      = rsp_rej_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTHESIS
   // Held count never goes past the table depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds table depth");

   // Writes only touch held slots or the one just above them
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) <= cnt_ff))
      else $error("table write outside held range");

   // An accepted transaction either starts work or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction produced nothing");

   // A result that is not the final one leaves the block busy
   a_more_results: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final result while idle");

   // Removal results are never flagged as refused
   a_removed_not_rej: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_removed_valid) |-> (!rsp_rejected && $past(busy)))
      else $error("removal result flagged as refused");
`endif

endmodule

// ===== rtl/stes_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry table; no dependencies.
`timescale 1ns / 1ps

module stes_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/stes_checker.sv =====
// Result checker for the sorted table with smallest-size eviction.
// Watches the command, result and APB ports, keeps a shadow table and compares.
// Depends on stes_pkg.
`timescale 1ns / 1ps

module stes_checker
   import stes_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic                   req_cmd,
   input  logic [TIME_W-1:0]      req_time_stamp,
   input  logic [SIZE_W-1:0]      req_entry_size,
   input  logic                   rsp_valid,
   input  logic                   rsp_removed_valid,
   input  logic [TIME_W-1:0]      rsp_removed_time,
   input  logic [SIZE_W-1:0]      rsp_removed_size,
   input  logic [TOTAL_W-1:0]     rsp_total_size,
   input  logic [COUNT_OUT_W-1:0] rsp_entry_count,
   input  logic                   rsp_rejected,
   input  logic                   rsp_last,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]            pwdata,
   input  logic [31:0]            prdata,
   input  logic                   pready,
   output int                     fail_count,
   output int                     due_count
);

   typedef struct packed {
      logic                   removed_valid;
      logic [TIME_W-1:0]      removed_time;
      logic [SIZE_W-1:0]      removed_size;
      logic [TOTAL_W-1:0]     total_size;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   rejected;
      logic                   last;
   } table_rsp_type;

   // shadow copy of the table, ordered by rising stamp
   logic [TIME_W-1:0] shadow_stamp [DEPTH];
   logic [SIZE_W-1:0] shadow_size  [DEPTH];
   int unsigned       held;
   int unsigned       held_total;
   int unsigned       capacity;

   table_rsp_type rsp_due_q[$];
   table_rsp_type want;

   initial begin
      fail_count = 0;
      due_count  = 0;
      held       = 0;
      held_total = 0;
      capacity   = CAP_RESET;
   end

   // result as it must look with the current table state
   function automatic table_rsp_type make_rsp(input logic valid,
                                              input logic [TIME_W-1:0] stamp,
                                              input logic [SIZE_W-1:0] size,
                                              input logic rej, input logic fin);
      table_rsp_type r;
      r.removed_valid = valid;
      r.removed_time  = stamp;
      r.removed_size  = size;
      r.total_size    = TOTAL_W'(held_total);
      r.entry_count   = COUNT_OUT_W'(held);
      r.rejected      = rej;
      r.last          = fin;
      return r;
   endfunction

   // apply one command to the shadow table, queue the results it causes
   task automatic table_apply_cmd(input logic cmd, input logic [TIME_W-1:0] stamp,
                                  input logic [SIZE_W-1:0] size);
      int unsigned       pos;
      int unsigned       low;
      logic [TIME_W-1:0] gone_stamp;
      logic [SIZE_W-1:0] gone_size;
      bit                removed_any;
      bit                more;
      if (cmd == CMD_INSERT) begin
         if (held >= DEPTH || held_total + size > TOTAL_MAX) begin
            rsp_due_q.push_back(make_rsp(1'b0, '0, '0, 1'b1, 1'b1));
         end else begin
            // goes after every entry with a stamp not above its own
            pos = 0;
            while (pos < held && shadow_stamp[pos] <= stamp) pos++;
            for (int unsigned i = held; i > pos; i--) begin
               shadow_stamp[i] = shadow_stamp[i-1];
               shadow_size[i]  = shadow_size[i-1];
            end
            shadow_stamp[pos] = stamp;
            shadow_size[pos]  = size;
            held++;
            held_total += size;
            rsp_due_q.push_back(make_rsp(1'b0, '0, '0, 1'b0, 1'b1));
         end
      end else begin
         removed_any = 1'b0;
         more = (held_total > capacity) && (held > 0);
         while (more) begin
            // strictly smallest size, earliest slot wins a tie
            low = 0;
            for (int unsigned i = 1; i < held; i++)
               if (shadow_size[i] < shadow_size[low]) low = i;
            gone_stamp = shadow_stamp[low];
            gone_size  = shadow_size[low];
            for (int unsigned i = low; i + 1 < held; i++) begin
               shadow_stamp[i] = shadow_stamp[i+1];
               shadow_size[i]  = shadow_size[i+1];
            end
            held--;
            held_total -= gone_size;
            more = (held_total > capacity) && (held > 0);
            rsp_due_q.push_back(make_rsp(1'b1, gone_stamp, gone_size, 1'b0, !more));
            removed_any = 1'b1;
         end
         if (!removed_any)
            rsp_due_q.push_back(make_rsp(1'b0, '0, '0, 1'b0, 1'b1));
      end
   endtask

   task automatic check_field(input string label, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, exp_val, act_val);
      end
   endtask

   // results first, then register access, then a newly taken command
   always @(posedge clock) begin
      if (reset) begin
         held       = 0;
         held_total = 0;
         capacity   = CAP_RESET;
         rsp_due_q.delete();
      end else begin
         if (rsp_valid) begin
            if (rsp_due_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual time %0h size %0h",
                        $time, rsp_removed_time, rsp_removed_size);
            end else begin
               want = rsp_due_q.pop_front();
               check_field("removed_valid", want.removed_valid, rsp_removed_valid);
               check_field("removed_time", want.removed_time, rsp_removed_time);
               check_field("removed_size", want.removed_size, rsp_removed_size);
               check_field("total_size", want.total_size, rsp_total_size);
               check_field("entry_count", want.entry_count, rsp_entry_count);
               check_field("rejected", want.rejected, rsp_rejected);
               check_field("last", want.last, rsp_last);
            end
         end
         if (psel && penable && pready && paddr[CSR_ADDR_W-1:2] == CSR_CAPACITY) begin
            if (pwrite)
               capacity = pwdata[TOTAL_W-1:0];
            else
               check_field("capacity readback", capacity, prdata[TOTAL_W-1:0]);
         end
         if (start && !busy)
            table_apply_cmd(req_cmd, req_time_stamp, req_entry_size);
      end
      due_count = rsp_due_q.size();
   end

endmodule

// ===== sim/sorted_table_evict_smallest_tb.sv =====
// Testbench top for the sorted table with smallest-size eviction.
// Drives directed and bursty random commands plus capacity writes; stes_checker
// does the predicting and comparing. Depends on stes_pkg and stes_checker.
`timescale 1ns / 1ps

module sorted_table_evict_smallest_tb;
   import stes_pkg::*;

   localparam int          CLK_PERIOD = 12;
   localparam int          DEPTH      = DEFAULT_DEPTH;
   localparam int unsigned RUN_LIMIT  = 4000000;
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = {CSR_CAPACITY, 2'b00};

   typedef enum {SZ_FULL, SZ_NARROW, SZ_MAX} size_mix_type;
   typedef enum {TS_FULL, TS_NARROW} stamp_mix_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_cmd = CMD_INSERT;
   logic [TIME_W-1:0]      req_time_stamp = '0;
   logic [SIZE_W-1:0]      req_entry_size = '0;
   logic                   rsp_valid;
   logic                   rsp_removed_valid;
   logic [TIME_W-1:0]      rsp_removed_time;
   logic [SIZE_W-1:0]      rsp_removed_size;
   logic [TOTAL_W-1:0]     rsp_total_size;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic                   rsp_rejected;
   logic                   rsp_last;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr = '0;
   logic [31:0]            pwdata = '0;
   logic [31:0]            prdata;
   logic                   pready;
   int                     fail_count;
   int                     due_count;
   int unsigned            cycle_count = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   sorted_table_evict_smallest #(.DEPTH(DEPTH)) i_dut (.*);

   stes_checker #(.DEPTH(DEPTH)) i_checker (.*);

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, due_count);
         $display("simulation failed");
         $finish;
      end
   end

   // one command transaction; called at a falling edge, returns at one
   task automatic send_cmd(input logic cmd, input logic [TIME_W-1:0] stamp,
                           input logic [SIZE_W-1:0] size);
      start          = 1'b1;
      req_cmd        = cmd;
      req_time_stamp = stamp;
      req_entry_size = size;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_for(input int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // hold off until every result is in and the block is idle
   task automatic wait_drained();
      start = 1'b0;
      while (due_count != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // capacity write with junk above the field, then a read back
   task automatic write_capacity(input logic [TOTAL_W-1:0] cap);
      wait_drained();
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CAP_ADDR;
      pwdata  = {11'($urandom), cap};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // random commands in bursts with optional gaps between them
   task automatic run_phase(input int n_items, input int insert_pct,
                            input size_mix_type size_mix,
                            input stamp_mix_type stamp_mix, input bit gaps_on);
      int                sent;
      int                burst;
      logic              cmd;
      logic [TIME_W-1:0] stamp;
      logic [SIZE_W-1:0] size;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < n_items; k++) begin
            cmd   = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EVICT;
            stamp = (stamp_mix == TS_NARROW) ? TIME_W'($urandom_range(0, 15)) : $urandom;
            case (size_mix)
               SZ_NARROW: size = SIZE_W'($urandom_range(0, 7));
               SZ_MAX:    size = ($urandom_range(0, 7) == 0) ? SIZE_W'($urandom) : '1;
               default:   size = SIZE_W'($urandom);
            endcase
            send_cmd(cmd, stamp, size);
            sent++;
         end
         if (gaps_on) idle_for($urandom_range(0, 6));
      end
      start = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: empty evict, key extremes, equal stamps, size ties
      send_cmd(CMD_EVICT, '1, '1);
      send_cmd(CMD_INSERT, 32'd100, 16'd10);
      send_cmd(CMD_INSERT, 32'd100, 16'd10);
      send_cmd(CMD_INSERT, 32'd0, 16'hFFFF);
      send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'd0);
      idle_for(3);
      send_cmd(CMD_INSERT, 32'd50, 16'd10);
      send_cmd(CMD_INSERT, 32'd100, 16'd5);
      // total above the reset capacity: drains down to nothing
      send_cmd(CMD_EVICT, 32'd0, 16'd0);
      send_cmd(CMD_INSERT, 32'd7, 16'd3);
      send_cmd(CMD_EVICT, 32'd0, 16'd0);

      // zero capacity: evict removes every entry, the zero-sized ones first
      write_capacity('0);
      send_cmd(CMD_INSERT, 32'd9, 16'd0);
      send_cmd(CMD_INSERT, 32'd9, 16'd4);
      send_cmd(CMD_INSERT, 32'd2, 16'd0);
      send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      send_cmd(CMD_EVICT, 32'd0, 16'd0);
      send_cmd(CMD_EVICT, 32'd0, 16'd0);

      // top capacity: nothing to remove
      write_capacity(TOTAL_MAX);
      send_cmd(CMD_INSERT, 32'h8000_0000, 16'h8000);
      send_cmd(CMD_EVICT, 32'd0, 16'd0);
      idle_for(2);

      // random phases, a capacity setting each
      write_capacity(TOTAL_MAX);
      run_phase(48, 92, SZ_FULL, TS_FULL, 1'b1);
      write_capacity(CAP_RESET);
      run_phase(40, 60, SZ_FULL, TS_NARROW, 1'b1);
      write_capacity('0);
      run_phase(30, 70, SZ_NARROW, TS_NARROW, 1'b0);
      write_capacity(TOTAL_W'($urandom_range(0, 200)));
      run_phase(40, 75, SZ_NARROW, TS_FULL, 1'b1);
      write_capacity(TOTAL_MAX);
      run_phase(40, 95, SZ_MAX, TS_FULL, 1'b1);
      write_capacity(TOTAL_W'($urandom_range(0, 2097151)));
      run_phase(40, 65, SZ_FULL, TS_FULL, 1'b1);
      write_capacity(TOTAL_W'(1));
      run_phase(40, 70, SZ_FULL, TS_FULL, 1'b0);
      write_capacity(TOTAL_W'($urandom_range(1000, 600000)));
      run_phase(42, 70, SZ_FULL, TS_NARROW, 1'b1);

      // drain, then allow for one more table walk
      wait_drained();
      repeat (2 * DEPTH + 10) @(negedge clock);
      if (fail_count == 0 && due_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/stes_pkg.sv
rtl/stes_ram.sv
rtl/sorted_table_evict_smallest.sv
sim/stes_checker.sv
sim/sorted_table_evict_smallest_tb.sv
